[sv/bbp_pkg.sv]
// shared types and constants of the bandpass filter bank
package bbp_pkg;

    localparam int ENERGY_W = 48;
    localparam int CFG_W    = 5;
    localparam int CH_OUT_W = 4;
    localparam int RES_LIM  = 16;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // per-channel micro steps of the shared multiply-accumulate
    typedef enum logic [2:0] {
        PH_GAIN_X  = 3'd0,
        PH_GAIN_X2 = 3'd1,
        PH_FB1     = 3'd2,
        PH_FB2     = 3'd3,
        PH_SUM     = 3'd4,
        PH_ROUND   = 3'd5,
        PH_SQUARE  = 3'd6,
        PH_RETIRE  = 3'd7
    } t_phase;

    typedef struct packed {
        logic shift;
        logic clr_hist;
        logic clr_energy;
        logic load;
    } t_cell_ctl;

endpackage

[sv/bbp_if.sv]
// handshake channels of the filter bank: input items and result items
interface bbp_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 20
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [3:0]                    channel_index;
    logic signed [COEF_BITS-1:0]   coef_b0;
    logic signed [COEF_BITS-1:0]   coef_a1;
    logic signed [COEF_BITS-1:0]   coef_a2;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;

    modport source (output valid, kind, channel_index, coef_b0, coef_a1, coef_a2,
                    sample, block_end, input ready);
    modport sink   (input valid, kind, channel_index, coef_b0, coef_a1, coef_a2,
                    sample, block_end, output ready);
endinterface

interface bbp_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [3:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic [3:0]                    peak_idx;
    logic                          peak_valid;
    logic                          last;

    modport source (output valid, channel, filtered, peak_idx, peak_valid, last,
                    input ready);
    modport sink   (input valid, channel, filtered, peak_idx, peak_valid, last,
                    output ready);
endinterface

[sv/bbp_cell.sv]
// one channel cell: coefficients, histories and energy, shifts toward the head
module bbp_cell
    import bbp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [COEF_BITS-1:0]   i_ld_b0,
    input  logic signed [COEF_BITS-1:0]   i_ld_a1,
    input  logic signed [COEF_BITS-1:0]   i_ld_a2,
    input  logic signed [COEF_BITS-1:0]   i_nx_b0,
    input  logic signed [COEF_BITS-1:0]   i_nx_a1,
    input  logic signed [COEF_BITS-1:0]   i_nx_a2,
    input  logic signed [SAMPLE_BITS-1:0] i_nx_x1,
    input  logic signed [SAMPLE_BITS-1:0] i_nx_x2,
    input  logic signed [SAMPLE_BITS-1:0] i_nx_y1,
    input  logic signed [SAMPLE_BITS-1:0] i_nx_y2,
    input  logic [ENERGY_W-1:0]           i_nx_e,
    output logic signed [COEF_BITS-1:0]   o_b0,
    output logic signed [COEF_BITS-1:0]   o_a1,
    output logic signed [COEF_BITS-1:0]   o_a2,
    output logic signed [SAMPLE_BITS-1:0] o_x1,
    output logic signed [SAMPLE_BITS-1:0] o_x2,
    output logic signed [SAMPLE_BITS-1:0] o_y1,
    output logic signed [SAMPLE_BITS-1:0] o_y2,
    output logic [ENERGY_W-1:0]           o_e
);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_b0 <= '0;
            o_a1 <= '0;
            o_a2 <= '0;
            o_x1 <= '0;
            o_x2 <= '0;
            o_y1 <= '0;
            o_y2 <= '0;
            o_e  <= '0;
        end else if (i_ctl.shift) begin
            o_b0 <= i_nx_b0;
            o_a1 <= i_nx_a1;
            o_a2 <= i_nx_a2;
            o_x1 <= i_nx_x1;
            o_x2 <= i_nx_x2;
            o_y1 <= i_nx_y1;
            o_y2 <= i_nx_y2;
            o_e  <= i_nx_e;
        end else begin
            if (i_ctl.load) begin
                o_b0 <= i_ld_b0;
                o_a1 <= i_ld_a1;
                o_a2 <= i_ld_a2;
            end
            if (i_ctl.clr_hist) begin
                o_x1 <= '0;
                o_x2 <= '0;
                o_y1 <= '0;
                o_y2 <= '0;
            end
            if (i_ctl.clr_energy) begin
                o_e <= '0;
            end
        end
    end

endmodule

[sv/biquad_bandpass_bank_peak_unit.sv]
// top level of the bandpass biquad filter bank with block peak detection
//
//  channel   dir  handshake      transaction
//  i_in      in   valid/ready    load coefficients, sample or clear
//  o_out     out  valid/ready    one filtered value of one channel
//  i_cfg_*   in   write enable   active channel count
//
//  a sample steps each active channel through the phases of the one shared
//  multiplier and lets each idle cell of the ring pass by (MAX_CHANNELS cells in
//  all); no new transaction is taken until the whole ring has turned
//  load and clear are taken while idle and leave the unit idle
//  reset clears coefficients, histories and energies at once, count back to 10
//  a result waiting in the output register stalls only the retire step
module biquad_bandpass_bank_peak_unit
    import bbp_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16,
    parameter int COEF_BITS    = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bbp_in_if.sink           i_in,
    bbp_out_if.source        o_out
);

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int SUM_W  = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;
    localparam int LIM    = (MAX_CHANNELS < RES_LIM) ? MAX_CHANNELS : RES_LIM;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_BITS - 3);
    localparam logic signed [ACC_W-1:0] YMAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] YMIN = -YMAX - 1;
    localparam logic [ENERGY_W-1:0]     EMAX = '1;

    // ring of channel cells, cell 0 is the head at the multiplier
    logic signed [COEF_BITS-1:0]   s_b0 [MAX_CHANNELS+1];
    logic signed [COEF_BITS-1:0]   s_a1 [MAX_CHANNELS+1];
    logic signed [COEF_BITS-1:0]   s_a2 [MAX_CHANNELS+1];
    logic signed [SAMPLE_BITS-1:0] s_x1 [MAX_CHANNELS+1];
    logic signed [SAMPLE_BITS-1:0] s_x2 [MAX_CHANNELS+1];
    logic signed [SAMPLE_BITS-1:0] s_y1 [MAX_CHANNELS+1];
    logic signed [SAMPLE_BITS-1:0] s_y2 [MAX_CHANNELS+1];
    logic [ENERGY_W-1:0]           s_e  [MAX_CHANNELS+1];
    t_cell_ctl                     w_ctl [MAX_CHANNELS];

    t_state                        r_state, n_state;
    t_phase                        r_ph;
    logic [CNT_W-1:0]              r_ch;
    logic [CFG_W-1:0]              r_count;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_bend;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic [SQ_W-1:0]               r_sq;
    logic [ENERGY_W-1:0]           r_best;
    logic [CNT_W-1:0]              r_peak;
    logic                          r_ov;
    logic [3:0]                    r_och;
    logic signed [SAMPLE_BITS-1:0] r_oy;
    logic [3:0]                    r_opk;
    logic                          r_opv;
    logic                          r_olast;

    logic [CFG_W-1:0]              w_active;
    logic                          w_ch_on;
    logic                          w_ch_last;
    logic                          w_out_free;
    logic                          w_retire;
    logic                          w_step;
    logic                          w_acc_in;
    logic                          w_start;
    logic                          w_load;
    logic                          w_clear;
    logic                          w_empty_end;
    logic signed [COEF_BITS-1:0]   w_op_a;
    logic signed [SAMPLE_BITS-1:0] w_op_b;
    logic signed [ACC_W-1:0]       w_rnd;
    logic [SUM_W-1:0]              w_sum;
    logic [ENERGY_W-1:0]           w_new_e;
    logic                          w_win;

    // active count clamped to the ring size and to the result limit
    always_comb begin
        w_active = (r_count > CFG_W'(LIM)) ? CFG_W'(LIM) : r_count;
    end

    assign w_ch_on    = CMP_W'(r_ch) < CMP_W'(w_active);
    assign w_ch_last  = CMP_W'(r_ch) + CMP_W'(1) == CMP_W'(w_active);
    assign w_out_free = !r_ov || o_out.ready;
    assign w_acc_in   = i_in.valid && i_in.ready;

    // ring shifts after an active channel retires or an idle cell passes by
    assign w_retire = (r_state == ST_RUN) && w_ch_on && (r_ph == PH_RETIRE) && w_out_free;
    assign w_step   = w_retire || ((r_state == ST_RUN) && !w_ch_on);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_step && (r_ch == CNT_W'(MAX_CHANNELS - 1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready  = 1'b0;
        w_start     = 1'b0;
        w_load      = 1'b0;
        w_clear     = 1'b0;
        w_empty_end = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (w_acc_in) begin
                    case (t_kind'(i_in.kind))
                        KIND_LOAD:   w_load = 1'b1;
                        KIND_CLEAR:  w_clear = 1'b1;
                        KIND_SAMPLE: begin
                            if (w_active != '0) begin
                                w_start = 1'b1;
                            end else begin
                                w_empty_end = i_in.block_end;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: ;
            default: ;
        endcase
    end

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
        always_comb begin
            w_ctl[i].shift      = w_step;
            w_ctl[i].clr_hist   = w_clear;
            w_ctl[i].clr_energy = w_clear || w_empty_end;
            w_ctl[i].load       = w_load && (32'(i_in.channel_index) == i);
        end

        bbp_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[i]),
            .i_ld_b0 (i_in.coef_b0),
            .i_ld_a1 (i_in.coef_a1),
            .i_ld_a2 (i_in.coef_a2),
            .i_nx_b0 (s_b0[i+1]),
            .i_nx_a1 (s_a1[i+1]),
            .i_nx_a2 (s_a2[i+1]),
            .i_nx_x1 (s_x1[i+1]),
            .i_nx_x2 (s_x2[i+1]),
            .i_nx_y1 (s_y1[i+1]),
            .i_nx_y2 (s_y2[i+1]),
            .i_nx_e  (s_e[i+1]),
            .o_b0    (s_b0[i]),
            .o_a1    (s_a1[i]),
            .o_a2    (s_a2[i]),
            .o_x1    (s_x1[i]),
            .o_x2    (s_x2[i]),
            .o_y1    (s_y1[i]),
            .o_y2    (s_y2[i]),
            .o_e     (s_e[i])
        );
    end

    // write-back of the head channel into the tail of the ring
    always_comb begin
        s_b0[MAX_CHANNELS] = s_b0[0];
        s_a1[MAX_CHANNELS] = s_a1[0];
        s_a2[MAX_CHANNELS] = s_a2[0];
        s_x1[MAX_CHANNELS] = w_ch_on ? r_x : s_x1[0];
        s_x2[MAX_CHANNELS] = w_ch_on ? s_x1[0] : s_x2[0];
        s_y1[MAX_CHANNELS] = w_ch_on ? r_y : s_y1[0];
        s_y2[MAX_CHANNELS] = w_ch_on ? s_y1[0] : s_y2[0];
        if (r_bend) begin
            s_e[MAX_CHANNELS] = '0;
        end else begin
            s_e[MAX_CHANNELS] = w_ch_on ? w_new_e : s_e[0];
        end
    end

    // operand select of the shared multiplier
    always_comb begin
        case (r_ph)
            PH_GAIN_X: begin
                w_op_a = s_b0[0];
                w_op_b = r_x;
            end
            PH_GAIN_X2: begin
                w_op_a = s_b0[0];
                w_op_b = s_x2[0];
            end
            PH_FB1: begin
                w_op_a = s_a1[0];
                w_op_b = s_y1[0];
            end
            PH_FB2: begin
                w_op_a = s_a2[0];
                w_op_b = s_y2[0];
            end
            default: begin
                w_op_a = s_a2[0];
                w_op_b = s_y2[0];
            end
        endcase
    end

    // round half up, then drop the fraction
    assign w_rnd = (r_acc + RND) >>> (COEF_BITS - 2);

    // saturating energy update and strictly-greater peak compare
    always_comb begin
        w_sum   = SUM_W'(s_e[0]) + SUM_W'(r_sq);
        w_new_e = (w_sum > SUM_W'(EMAX)) ? EMAX : ENERGY_W'(w_sum);
        w_win   = w_new_e > r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= PH_GAIN_X;
            r_ch    <= '0;
            r_count <= CFG_W'(10);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_start) begin
                r_ph <= PH_GAIN_X;
                r_ch <= '0;
            end else if (w_step) begin
                r_ph <= PH_GAIN_X;
                r_ch <= (r_ch == CNT_W'(MAX_CHANNELS - 1)) ? '0 : r_ch + CNT_W'(1);
            end else if ((r_state == ST_RUN) && (r_ph != PH_RETIRE)) begin
                r_ph <= t_phase'(r_ph + 3'd1);
            end
            if (w_retire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_x    <= i_in.sample;
            r_bend <= i_in.block_end;
            r_best <= '0;
            r_peak <= '0;
        end
        r_prod <= w_op_a * w_op_b;
        case (r_ph)
            PH_GAIN_X2: r_acc <= ACC_W'(r_prod);
            PH_FB1, PH_FB2, PH_SUM: r_acc <= r_acc - ACC_W'(r_prod);
            default: ;
        endcase
        if (r_ph == PH_ROUND) begin
            if (w_rnd > YMAX) begin
                r_y <= SAMPLE_BITS'(YMAX);
            end else if (w_rnd < YMIN) begin
                r_y <= SAMPLE_BITS'(YMIN);
            end else begin
                r_y <= SAMPLE_BITS'(w_rnd);
            end
        end
        if (r_ph == PH_SQUARE) begin
            r_sq <= SQ_W'(r_y * r_y);
        end
        if (w_retire) begin
            if (w_win) begin
                r_best <= w_new_e;
                r_peak <= r_ch;
            end
            r_och   <= 4'(r_ch);
            r_oy    <= r_y;
            r_olast <= w_ch_last;
            r_opv   <= w_ch_last && r_bend;
            if (w_ch_last && r_bend) begin
                r_opk <= w_win ? 4'(r_ch) : 4'(r_peak);
            end else begin
                r_opk <= '0;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.channel    = r_och;
    assign o_out.filtered   = r_oy;
    assign o_out.peak_idx   = r_opk;
    assign o_out.peak_valid = r_opv;
    assign o_out.last       = r_olast;

`ifndef SYNTHESIS
    a_peak_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.peak_valid |-> o_out.last)
        else $error("peak reported on a result that is not the last");

    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && (n_state == ST_IDLE) |-> r_ch == CNT_W'(MAX_CHANNELS - 1))
        else $error("ring left out of alignment at end of sample");

    a_no_input_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> !i_in.ready)
        else $error("input accepted while a sample is in flight");

    a_retire_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_retire |=> r_ov && (o_out.channel == $past(4'(r_ch))))
        else $error("retired result lost in output register");
`endif

endmodule
